// ===== sv/msc_pkg.sv =====
// Shared types, constants and CRC functions of the MFM sector CRC fixer.
package msc_pkg;

   localparam int unsigned MaxSizeCode = 6;

   localparam logic [15:0] TrackLengthReset = 16'd6250;
   localparam logic [15:0] CrcInit          = 16'hFFFF;
   localparam logic [15:0] CrcPoly          = 16'h1021;
   localparam logic [31:0] IdMark           = 32'hA1A1A1FE;
   localparam logic [31:0] DataMark         = 32'hA1A1A1FB;
   localparam logic [14:0] BodyBase         = 15'd128;
   localparam logic [16:0] IdFieldRoom      = 17'd6;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ID,
      PH_DATA,
      PH_CRCH,
      PH_CRCL
   } phase_type;

   typedef enum logic [1:0] {
      KIND_GAP  = 2'd0,
      KIND_ID   = 2'd1,
      KIND_DATA = 2'd2,
      KIND_CRC  = 2'd3
   } field_kind_type;

   // Item handed from the front part to the parser.
   typedef struct packed {
      logic [7:0]  track_byte;
      logic        new_track;
      logic [15:0] room;
   } link_item_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       crc_checked;
      logic       crc_mismatch;
      logic [1:0] field_kind;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_of_mark(input logic [31:0] mark);
      logic [15:0] c;
      c = crc_byte(CrcInit, mark[31:24]);
      c = crc_byte(c, mark[23:16]);
      c = crc_byte(c, mark[15:8]);
      c = crc_byte(c, mark[7:0]);
      return c;
   endfunction

   localparam logic [15:0] IdMarkCrc   = crc_of_mark(IdMark);
   localparam logic [15:0] DataMarkCrc = crc_of_mark(DataMark);

endpackage

// ===== sv/mfm_sector_crc_fixer_unit.sv =====
// Top level of the MFM sector CRC fixer: queue ports, register port and the two parts.
//
// The unit takes the raw bytes of an MFM track one transaction at a time and
// returns one result transaction for each, in order. Bytes pass through
// unchanged, except that the two stored CRC bytes after an ID field or a data
// field are replaced by the correct CRC-16-CCITT over the mark and the body;
// crc_checked and crc_mismatch report on the second CRC byte whether the stored
// value was wrong. A byte with track_start set, or one that arrives after
// track_length bytes, begins a new track. The unit sustains one byte per
// clock while the result queue has room: the front part keeps the track
// position and works out the room left in the track, and the parser in the
// back part updates the CRC one byte per cycle; each byte is registered in
// the link queue, then its result in the result queue. Two-entry queues sit
// between the parts and at the output, so a stall on either side is buffered
// before it stops the other. The track_length register sits at byte address
// 0 and should only be written while no transaction is in flight.
module mfm_sector_crc_fixer_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_track_byte,
   input  logic        req_track_start,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_crc_checked,
   output logic        rsp_crc_mismatch,
   output logic [1:0]  rsp_field_kind,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import msc_pkg::*;

   logic [15:0]   track_length_ff;
   logic          accept;
   link_item_type front_item;
   link_item_type head_item;
   logic          link_empty;
   logic          link_take;
   result_type    result;

   // Only one register exists, so every write lands in track_length.
   assign pready = 1'b1;
   assign prdata = {16'd0, track_length_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         track_length_ff <= TrackLengthReset;
      end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
         track_length_ff <= pwdata[15:0];
      end else if (psel && penable && pwrite && pready) begin
         track_length_ff <= pwdata[15:0];
      end
   end

   assign accept = push && !full;

   msc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .track_byte   (req_track_byte),
      .track_start  (req_track_start),
      .track_length (track_length_ff),
      .item         (front_item)
   );

   msc_link_queue u_link (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata (front_item),
      .full  (full),
      .pop   (link_take),
      .rdata (head_item),
      .empty (link_empty)
   );

   msc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item         (head_item),
      .item_valid   (!link_empty),
      .item_take    (link_take),
      .result       (result),
      .result_empty (empty),
      .result_pop   (pop)
   );

   assign rsp_byte_out     = result.byte_out;
   assign rsp_crc_checked  = result.crc_checked;
   assign rsp_crc_mismatch = result.crc_mismatch;
   assign rsp_field_kind   = result.field_kind;

endmodule

// ===== sv/msc_front.sv =====
// Front part: tracks the byte position and tags each byte with the new-track flag and the room left in the track.
module msc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            track_byte,
   input  logic                  track_start,
   input  logic [15:0]           track_length,
   output msc_pkg::link_item_type item
);
   import msc_pkg::*;

   logic [15:0] position_ff;
   logic [15:0] position_in;
   logic        new_track;
   logic [15:0] pos_eff;
   logic [16:0] diff;

   // A track start, or running past the track length, begins a new track.
   always_comb begin
      new_track   = track_start || (position_ff >= track_length);
      pos_eff     = new_track ? 16'd0 : position_ff;
      position_in = pos_eff + 16'd1;
      diff        = {1'b0, track_length} - {1'b0, position_in};
      item.track_byte = track_byte;
      item.new_track  = new_track;
      item.room       = diff[16] ? 16'd0 : diff[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 16'd0;
      end else if (accept) begin
         position_ff <= position_in;
      end
   end

endmodule

// ===== sv/msc_link_queue.sv =====
// Two-entry queue between the front part and the field parser.
module msc_link_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  msc_pkg::link_item_type wdata,
   output logic                   full,
   input  logic                   pop,
   output msc_pkg::link_item_type rdata,
   output logic                   empty
);
   import msc_pkg::*;

   link_item_type entry_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

// ===== sv/msc_back.sv =====
// Back part: mark search, field parser, CRC update and result queue.
module msc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  msc_pkg::link_item_type item,
   input  logic                   item_valid,
   output logic                   item_take,
   output msc_pkg::result_type    result,
   output logic                   result_empty,
   input  logic                   result_pop
);
   import msc_pkg::*;

   phase_type   phase_ff, phase_in, phase_eff;
   logic [31:0] shift_ff, shift_in, shift_eff;
   logic [13:0] left_ff, left_in, left_eff;
   logic [7:0]  size_ff, size_in, size_eff;
   logic [15:0] crc_ff, crc_in;
   logic        hbd_ff, hbd_in, hbd_eff;

   logic [7:0]  b;
   logic [31:0] shift_cand;
   logic [14:0] body;
   logic        id_ok;
   logic        data_ok;
   result_type  res;

   result_type  out_ff [2];
   logic        out_wr_ff;
   logic        out_rd_ff;
   logic [1:0]  out_count_ff;
   logic        out_full;
   logic        out_pop;

   assign out_full  = (out_count_ff == 2'd2);
   assign item_take = item_valid && !out_full;
   assign out_pop   = result_pop && !result_empty;

   // Parser state as seen by this byte, after any new-track clear.
   always_comb begin
      b          = item.track_byte;
      phase_eff  = item.new_track ? PH_IDLE : phase_ff;
      shift_eff  = item.new_track ? 32'd0 : shift_ff;
      left_eff   = item.new_track ? 14'd0 : left_ff;
      size_eff   = item.new_track ? 8'd0 : size_ff;
      hbd_eff    = item.new_track ? 1'b0 : hbd_ff;
      shift_cand = {shift_eff[23:0], b};
      body       = BodyBase << size_eff[2:0];
      id_ok      = (shift_cand == IdMark) && ({1'b0, item.room} >= IdFieldRoom);
      data_ok    = (shift_cand == DataMark) && ({24'd0, size_eff} <= 32'(MaxSizeCode))
                   && ({1'b0, item.room} >= ({2'b00, body} + 17'd2));
   end

   // Next phase.
   always_comb begin
      case (phase_eff)
         PH_ID, PH_DATA: begin
            phase_in = (left_eff == 14'd0) ? PH_CRCH : phase_eff;
         end
         PH_CRCH: phase_in = PH_CRCL;
         PH_CRCL: phase_in = PH_IDLE;
         default: begin
            if (id_ok) begin
               phase_in = PH_ID;
            end else if (data_ok) begin
               phase_in = PH_DATA;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   // Data path and result for this byte.
   always_comb begin
      shift_in = shift_eff;
      left_in  = left_eff;
      size_in  = size_eff;
      crc_in   = crc_ff;
      hbd_in   = hbd_eff;
      res.byte_out     = b;
      res.crc_checked  = 1'b0;
      res.crc_mismatch = 1'b0;
      res.field_kind   = KIND_GAP;
      case (phase_eff)
         PH_ID, PH_DATA: begin
            res.field_kind = (phase_eff == PH_ID) ? KIND_ID : KIND_DATA;
            crc_in         = crc_byte(crc_ff, b);
            if (left_eff == 14'd0) begin
               if (phase_eff == PH_ID) begin
                  size_in = b;
               end
            end else begin
               left_in = left_eff - 14'd1;
            end
         end
         PH_CRCH: begin
            res.field_kind = KIND_CRC;
            res.byte_out   = crc_ff[15:8];
            hbd_in         = (b != crc_ff[15:8]);
         end
         PH_CRCL: begin
            res.field_kind   = KIND_CRC;
            res.byte_out     = crc_ff[7:0];
            res.crc_checked  = 1'b1;
            res.crc_mismatch = hbd_eff || (b != crc_ff[7:0]);
         end
         default: begin
            shift_in = shift_cand;
            if (id_ok) begin
               crc_in  = IdMarkCrc;
               left_in = 14'd3;
            end else if (data_ok) begin
               crc_in  = DataMarkCrc;
               left_in = 14'(body - 15'd1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= 32'd0;
         left_ff  <= 14'd0;
         size_ff  <= 8'd0;
         crc_ff   <= CrcInit;
         hbd_ff   <= 1'b0;
      end else if (item_take) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         size_ff  <= size_in;
         crc_ff   <= crc_in;
         hbd_ff   <= hbd_in;
      end
   end

   // Result queue.
   assign result       = out_ff[out_rd_ff];
   assign result_empty = (out_count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (item_take) begin
         out_ff[out_wr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         if (item_take) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
         out_count_ff <= out_count_ff + {1'b0, item_take} - {1'b0, out_pop};
      end
   end

endmodule
